>>> rtl/core/aps_pkg.sv
// aps_pkg: shared types, codes and limits of the auto pump sequencer
// no dependencies
package aps_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHECK_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_CHANGE_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INFLATION   = 3'd6;

    localparam logic [16:0] THR_MIN   = 17'd100;
    localparam logic [16:0] THR_MAX   = 17'd100000;
    localparam logic [15:0] PRE_MIN   = 16'd1000;
    localparam logic [15:0] PRE_MAX   = 16'd60000;
    localparam logic [14:0] PLS_MIN   = 15'd50;
    localparam logic [14:0] PLS_MAX   = 15'd20000;
    localparam logic [19:0] COOL_MAX  = 20'd600000;
    localparam logic [15:0] NOCH_MIN  = 16'd1000;
    localparam logic [15:0] NOCH_MAX  = 16'd60000;
    localparam logic [15:0] MINF_MAX  = 16'd50000;

    typedef enum logic [1:0] {
        MODE_STANDBY  = 2'd0,
        MODE_PRECHECK = 2'd1,
        MODE_COOLING  = 2'd2,
        MODE_ERROR    = 2'd3
    } mode_t;

    localparam logic [2:0] AN_NONE       = 3'd0;
    localparam logic [2:0] AN_UNSTABLE   = 3'd1;
    localparam logic [2:0] AN_PREREQ     = 3'd2;
    localparam logic [2:0] AN_PULSE_FAIL = 3'd3;
    localparam logic [2:0] AN_NO_CHANGE  = 3'd4;

    typedef struct packed {
        logic        enable;
        logic        clear;
        logic [16:0] thr;
        logic [15:0] pre;
        logic [14:0] pls;
        logic [19:0] cool;
        logic [15:0] noch;
        logic [15:0] minf;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  camera_id;
        logic [16:0] width;
        logic        frame_ok;
        logic [31:0] now_ms;
        logic        pump_open;
        logic        pulse_ok;
    } item_t;

    typedef struct packed {
        mode_t       mode;
        logic        pump_fire;
        logic [7:0]  fire_camera;
        logic [16:0] fire_width;
        logic [14:0] fire_pulse_ms;
        logic [2:0]  anomaly;
    } res_t;

endpackage

>>> rtl/core/aps_cfg.sv
// aps_cfg: configuration registers, saturated to their ranges on write
// depends on aps_pkg
module aps_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data,
    output aps_pkg::cfg_t                  cfg
);
    import aps_pkg::*;

    logic        enable_reg, enable_next;
    logic [16:0] thr_reg, thr_next;
    logic [15:0] pre_reg, pre_next;
    logic [14:0] pls_reg, pls_next;
    logic [19:0] cool_reg, cool_next;
    logic [15:0] noch_reg, noch_next;
    logic [15:0] minf_reg, minf_next;

    logic [16:0] d17;
    logic [15:0] d16;
    logic [14:0] d15;

    assign d17 = cfg_data[16:0];
    assign d16 = cfg_data[15:0];
    assign d15 = cfg_data[14:0];

    always_comb begin
        enable_next = enable_reg;
        thr_next    = thr_reg;
        pre_next    = pre_reg;
        pls_next    = pls_reg;
        cool_next   = cool_reg;
        noch_next   = noch_reg;
        minf_next   = minf_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_AUTO_ENABLE: enable_next = cfg_data[0];
                CFG_START_THRESHOLD: begin
                    thr_next = (d17 < THR_MIN) ? THR_MIN : (d17 > THR_MAX) ? THR_MAX : d17;
                end
                CFG_PRECHECK_MS: begin
                    pre_next = (d16 < PRE_MIN) ? PRE_MIN : (d16 > PRE_MAX) ? PRE_MAX : d16;
                end
                CFG_PULSE_MS: begin
                    pls_next = (d15 < PLS_MIN) ? PLS_MIN : (d15 > PLS_MAX) ? PLS_MAX : d15;
                end
                CFG_COOLDOWN_MS: begin
                    cool_next = (cfg_data > COOL_MAX) ? COOL_MAX : cfg_data;
                end
                CFG_NO_CHANGE_MS: begin
                    noch_next = (d16 < NOCH_MIN) ? NOCH_MIN : (d16 > NOCH_MAX) ? NOCH_MAX : d16;
                end
                CFG_MIN_INFLATION: begin
                    minf_next = (d16 > MINF_MAX) ? MINF_MAX : d16;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            thr_reg    <= THR_MIN;
            pre_reg    <= PRE_MIN;
            pls_reg    <= PLS_MIN;
            cool_reg   <= '0;
            noch_reg   <= NOCH_MIN;
            minf_reg   <= '0;
        end else begin
            enable_reg <= enable_next;
            thr_reg    <= thr_next;
            pre_reg    <= pre_next;
            pls_reg    <= pls_next;
            cool_reg   <= cool_next;
            noch_reg   <= noch_next;
            minf_reg   <= minf_next;
        end
    end

    // disabling clears the run state in the same cycle
    assign cfg.clear  = cfg_we && (cfg_index == CFG_AUTO_ENABLE) && !cfg_data[0];
    assign cfg.enable = enable_reg;
    assign cfg.thr    = thr_reg;
    assign cfg.pre    = pre_reg;
    assign cfg.pls    = pls_reg;
    assign cfg.cool   = cool_reg;
    assign cfg.noch   = noch_reg;
    assign cfg.minf   = minf_reg;

endmodule

>>> rtl/core/aps_fsm.sv
// aps_fsm: mode machine state and the per-sample result logic
// depends on aps_pkg
module aps_fsm (
    input  logic           aclk,
    input  logic           aresetn,
    input  aps_pkg::cfg_t  cfg,
    input  aps_pkg::item_t item,
    input  logic           step,
    output aps_pkg::res_t  res
);
    import aps_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [31:0] last_pump_reg, last_pump_next;
    logic [16:0] start_width_reg, start_width_next;
    logic [7:0]  pump_camera_reg, pump_camera_next;
    logic        infl_seen_reg, infl_seen_next;
    logic        flagged_reg, flagged_next;

    logic [31:0] since_phase;
    logic [31:0] since_pump;
    logic [17:0] infl_target;
    logic        below_thr;

    assign since_phase = item.now_ms - phase_start_reg;
    assign since_pump  = item.now_ms - last_pump_reg;
    assign infl_target = {1'b0, start_width_reg} + {2'b00, cfg.minf};
    assign below_thr   = item.width < cfg.thr;

    always_comb begin
        mode_next        = mode_reg;
        phase_start_next = phase_start_reg;
        last_pump_next   = last_pump_reg;
        start_width_next = start_width_reg;
        pump_camera_next = pump_camera_reg;
        infl_seen_next   = infl_seen_reg;
        flagged_next     = flagged_reg;
        res.pump_fire     = 1'b0;
        res.fire_camera   = '0;
        res.fire_width    = '0;
        res.fire_pulse_ms = '0;
        res.anomaly       = AN_NONE;

        if (!cfg.enable) begin
            mode_next = MODE_STANDBY;
        end else if (mode_reg == MODE_ERROR) begin
            if (since_phase >= {12'd0, cfg.cool}) begin
                mode_next = MODE_STANDBY;
            end
        end else if (!item.frame_ok) begin
            res.anomaly      = AN_UNSTABLE;
            mode_next        = MODE_ERROR;
            phase_start_next = item.now_ms;
        end else begin
            case (mode_reg)
                MODE_STANDBY: begin
                    if (below_thr) begin
                        pump_camera_next = item.camera_id;
                        phase_start_next = item.now_ms;
                        mode_next        = MODE_PRECHECK;
                    end
                end
                MODE_PRECHECK: begin
                    if (!below_thr) begin
                        mode_next = MODE_STANDBY;
                    end else if (since_phase >= {16'd0, cfg.pre}) begin
                        if (!item.pump_open) begin
                            res.anomaly      = AN_PREREQ;
                            mode_next        = MODE_ERROR;
                            phase_start_next = item.now_ms;
                        end else begin
                            pump_camera_next = item.camera_id;
                            start_width_next = item.width;
                            infl_seen_next   = 1'b0;
                            flagged_next     = 1'b0;
                            phase_start_next = item.now_ms;
                            if (!item.pulse_ok) begin
                                res.anomaly = AN_PULSE_FAIL;
                                mode_next   = MODE_ERROR;
                            end else begin
                                last_pump_next    = item.now_ms;
                                mode_next         = MODE_COOLING;
                                res.pump_fire     = 1'b1;
                                res.fire_camera   = item.camera_id;
                                res.fire_width    = item.width;
                                res.fire_pulse_ms = cfg.pls;
                            end
                        end
                    end
                end
                default: begin
                    // cooling
                    infl_seen_next = infl_seen_reg || ({1'b0, item.width} >= infl_target);
                    if (!infl_seen_next && !flagged_reg &&
                        since_pump >= {16'd0, cfg.noch}) begin
                        flagged_next     = 1'b1;
                        res.anomaly      = AN_NO_CHANGE;
                        mode_next        = MODE_ERROR;
                        phase_start_next = item.now_ms;
                    end else if (since_phase >= {12'd0, cfg.cool}) begin
                        mode_next = MODE_STANDBY;
                    end
                end
            endcase
        end
        res.mode = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_STANDBY;
            phase_start_reg <= '0;
            last_pump_reg   <= '0;
            start_width_reg <= '0;
            pump_camera_reg <= '0;
            infl_seen_reg   <= 1'b0;
            flagged_reg     <= 1'b0;
        end else if (cfg.clear) begin
            mode_reg        <= MODE_STANDBY;
            phase_start_reg <= '0;
            start_width_reg <= '0;
            pump_camera_reg <= '0;
            infl_seen_reg   <= 1'b0;
            flagged_reg     <= 1'b0;
        end else if (step) begin
            mode_reg        <= mode_next;
            phase_start_reg <= phase_start_next;
            last_pump_reg   <= last_pump_next;
            start_width_reg <= start_width_next;
            pump_camera_reg <= pump_camera_next;
            infl_seen_reg   <= infl_seen_next;
            flagged_reg     <= flagged_next;
        end
    end

endmodule

>>> rtl/core/auto_pump_sequencer_unit.sv
// auto_pump_sequencer_unit: top level with input and result registers
// depends on aps_pkg, aps_cfg, aps_fsm
//
// Takes one width sample per cycle while the m_ side is not stalled. A sample
// accepted at one edge sits in the input register until it moves on to the
// result register, which captures the result of evaluating it against the mode
// machine; its single result transfer then appears on the m_ side. The input
// side accepts while the input register is empty or its sample moves on to the
// result register, which it does when the result register is empty or being
// taken. Configuration writes should be issued only while no sample is in
// flight; writing 0 to auto_enable resets the mode machine.
module auto_pump_sequencer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_camera_id,
    input  logic [16:0]                    s_width,
    input  logic                           s_frame_ok,
    input  logic [31:0]                    s_now_ms,
    input  logic                           s_pump_open,
    input  logic                           s_pulse_ok,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_mode,
    output logic                           m_pump_fire,
    output logic [7:0]                     m_fire_camera,
    output logic [16:0]                    m_fire_width,
    output logic [14:0]                    m_fire_pulse_ms,
    output logic [2:0]                     m_anomaly
);
    import aps_pkg::*;

    cfg_t  cfg;
    item_t item_reg, item_next;
    res_t  res, res_reg;
    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign item_next.camera_id = s_camera_id;
    assign item_next.width     = s_width;
    assign item_next.frame_ok  = s_frame_ok;
    assign item_next.now_ms    = s_now_ms;
    assign item_next.pump_open = s_pump_open;
    assign item_next.pulse_ok  = s_pulse_ok;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    aps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aps_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .step    (advance),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_mode          = res_reg.mode;
    assign m_pump_fire     = res_reg.pump_fire;
    assign m_fire_camera   = res_reg.fire_camera;
    assign m_fire_width    = res_reg.fire_width;
    assign m_fire_pulse_ms = res_reg.fire_pulse_ms;
    assign m_anomaly       = res_reg.anomaly;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for auto_pump_sequencer_unit, driving timestamped width samples
// depends on aps_pkg and the sequencer rtl; holds its own mode-machine predictor
module tb_top;
    import aps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        en;
        logic [16:0] thr;
        logic [15:0] pre;
        logic [14:0] pls;
        logic [19:0] cool;
        logic [15:0] noch;
        logic [15:0] minf;
    } seq_regs_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] phase_start;
        logic [31:0] last_pump;
        logic [16:0] start_width;
        logic [7:0]  pump_cam;
        logic        infl;
        logic        flagged;
    } seq_state_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_camera_id = '0;
    logic [16:0] s_width = '0;
    logic s_frame_ok = 1'b0;
    logic [31:0] s_now_ms = '0;
    logic s_pump_open = 1'b0;
    logic s_pulse_ok = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_mode;
    logic m_pump_fire;
    logic [7:0] m_fire_camera;
    logic [16:0] m_fire_width;
    logic [14:0] m_fire_pulse_ms;
    logic [2:0] m_anomaly;

    item_t sample_q[$];
    res_t due_results[$];
    seq_regs_t seq_regs;
    seq_state_t seq_st;
    logic [31:0] clock_ms;
    logic src_go = 1'b0;
    int gap_left = 0;
    int burst_left = 1;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic [15:0] rx_tick = '0;
    logic [1:0] rx_style = '0;
    int fail_cnt = 0;
    int cycle_cnt = 0;
    item_t next_item;
    item_t seen;
    res_t want;
    res_t calc;

    auto_pump_sequencer_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_camera_id     (s_camera_id),
        .s_width         (s_width),
        .s_frame_ok      (s_frame_ok),
        .s_now_ms        (s_now_ms),
        .s_pump_open     (s_pump_open),
        .s_pulse_ok      (s_pulse_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_pump_fire     (m_pump_fire),
        .m_fire_camera   (m_fire_camera),
        .m_fire_width    (m_fire_width),
        .m_fire_pulse_ms (m_fire_pulse_ms),
        .m_anomaly       (m_anomaly)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic seq_regs_t clamp_regs(input seq_regs_t raw);
        seq_regs_t e;
        e = raw;
        if (e.thr < THR_MIN) e.thr = THR_MIN;
        else if (e.thr > THR_MAX) e.thr = THR_MAX;
        if (e.pre < PRE_MIN) e.pre = PRE_MIN;
        else if (e.pre > PRE_MAX) e.pre = PRE_MAX;
        if (e.pls < PLS_MIN) e.pls = PLS_MIN;
        else if (e.pls > PLS_MAX) e.pls = PLS_MAX;
        if (e.cool > COOL_MAX) e.cool = COOL_MAX;
        if (e.noch < NOCH_MIN) e.noch = NOCH_MIN;
        else if (e.noch > NOCH_MAX) e.noch = NOCH_MAX;
        if (e.minf > MINF_MAX) e.minf = MINF_MAX;
        return e;
    endfunction

    // one sample through the mode machine
    task automatic advance_sequencer(inout seq_state_t st, input seq_regs_t raw,
                                     input item_t it, output res_t r);
        seq_regs_t c;
        logic [31:0] since_phase;
        logic [31:0] since_pump;
        logic [31:0] goal;
        c = clamp_regs(raw);
        r = '0;
        since_phase = it.now_ms - st.phase_start;
        since_pump = it.now_ms - st.last_pump;
        goal = 32'(st.start_width) + 32'(c.minf);
        if (!raw.en) begin
            st.mode = MODE_STANDBY;
        end else if (st.mode == MODE_ERROR) begin
            if (since_phase >= 32'(c.cool)) st.mode = MODE_STANDBY;
        end else if (!it.frame_ok) begin
            r.anomaly = AN_UNSTABLE;
            st.mode = MODE_ERROR;
            st.phase_start = it.now_ms;
        end else if (st.mode == MODE_STANDBY) begin
            if (it.width < c.thr) begin
                st.pump_cam = it.camera_id;
                st.phase_start = it.now_ms;
                st.mode = MODE_PRECHECK;
            end
        end else if (st.mode == MODE_PRECHECK) begin
            if (it.width >= c.thr) begin
                st.mode = MODE_STANDBY;
            end else if (since_phase >= 32'(c.pre)) begin
                if (!it.pump_open) begin
                    r.anomaly = AN_PREREQ;
                    st.mode = MODE_ERROR;
                    st.phase_start = it.now_ms;
                end else begin
                    st.pump_cam = it.camera_id;
                    st.start_width = it.width;
                    st.infl = 1'b0;
                    st.flagged = 1'b0;
                    st.phase_start = it.now_ms;
                    if (!it.pulse_ok) begin
                        r.anomaly = AN_PULSE_FAIL;
                        st.mode = MODE_ERROR;
                    end else begin
                        st.last_pump = it.now_ms;
                        st.mode = MODE_COOLING;
                        r.pump_fire = 1'b1;
                        r.fire_camera = it.camera_id;
                        r.fire_width = it.width;
                        r.fire_pulse_ms = c.pls;
                    end
                end
            end
        end else begin
            if (!st.infl && 32'(it.width) >= goal) st.infl = 1'b1;
            if (!st.infl && !st.flagged && since_pump >= 32'(c.noch)) begin
                st.flagged = 1'b1;
                r.anomaly = AN_NO_CHANGE;
                st.mode = MODE_ERROR;
                st.phase_start = it.now_ms;
            end else if (since_phase >= 32'(c.cool)) begin
                st.mode = MODE_STANDBY;
            end
        end
        r.mode = st.mode;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_AUTO_ENABLE: begin
                seq_regs.en = val[0];
                if (!val[0]) begin
                    seq_st.mode = MODE_STANDBY;
                    seq_st.phase_start = '0;
                    seq_st.start_width = '0;
                    seq_st.pump_cam = '0;
                    seq_st.infl = 1'b0;
                    seq_st.flagged = 1'b0;
                end
            end
            CFG_START_THRESHOLD: seq_regs.thr = val[16:0];
            CFG_PRECHECK_MS:     seq_regs.pre = val[15:0];
            CFG_PULSE_MS:        seq_regs.pls = val[14:0];
            CFG_COOLDOWN_MS:     seq_regs.cool = val[19:0];
            CFG_NO_CHANGE_MS:    seq_regs.noch = val[15:0];
            CFG_MIN_INFLATION:   seq_regs.minf = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [19:0] en, thr, pre, pls, cool, noch, minf);
        write_reg(CFG_AUTO_ENABLE, en);
        write_reg(CFG_START_THRESHOLD, thr);
        write_reg(CFG_PRECHECK_MS, pre);
        write_reg(CFG_PULSE_MS, pls);
        write_reg(CFG_COOLDOWN_MS, cool);
        write_reg(CFG_NO_CHANGE_MS, noch);
        write_reg(CFG_MIN_INFLATION, minf);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [19:0] draw_reg(input int unsigned lo, input int unsigned hi);
        if ($urandom_range(0, 4) == 0) return 20'($urandom);
        return 20'($urandom_range(lo, hi));
    endfunction

    task automatic push_sample(input logic [7:0] cam, input logic [16:0] w, input logic fok,
                               input logic [31:0] dt, input logic popen, input logic pok);
        item_t it;
        clock_ms = clock_ms + dt;
        it.camera_id = cam;
        it.width = w;
        it.frame_ok = fok;
        it.now_ms = clock_ms;
        it.pump_open = popen;
        it.pulse_ok = pok;
        sample_q.push_back(it);
    endtask

    // step near, onto or past a deadline, or a short step forward
    function automatic logic [31:0] pick_time(input logic [31:0] base, input logic [31:0] span);
        case ($urandom_range(0, 5))
            0, 1, 2: return clock_ms + $urandom_range(0, span / 4 + 1);
            3:       return base + span - 1;
            4:       return base + span;
            default: return base + span + $urandom_range(0, span + 10);
        endcase
    endfunction

    // steered samples: a shadow copy of the mode machine picks widths and times
    task automatic gen_phase(input int count);
        seq_state_t st;
        seq_regs_t c;
        item_t it;
        res_t r;
        logic [31:0] goal;
        logic [31:0] w;
        st = seq_st;
        c = clamp_regs(seq_regs);
        repeat (count) begin
            it.camera_id = 8'($urandom);
            it.frame_ok = ($urandom_range(0, 19) != 0);
            it.pump_open = ($urandom_range(0, 9) != 0);
            it.pulse_ok = ($urandom_range(0, 7) != 0);
            w = ($urandom_range(0, 4) != 0) ? $urandom_range(0, c.thr - 1)
                                            : $urandom_range(c.thr, 131071);
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom;
                it.frame_ok = 1'($urandom);
                clock_ms = ($urandom_range(0, 1) != 0) ? $urandom
                                                       : clock_ms + $urandom_range(0, 200000);
            end else begin
                case (st.mode)
                    MODE_STANDBY: clock_ms = clock_ms + $urandom_range(0, 300);
                    MODE_PRECHECK: begin
                        if ($urandom_range(0, 9) != 0) w = $urandom_range(0, c.thr - 1);
                        clock_ms = pick_time(st.phase_start, 32'(c.pre));
                    end
                    MODE_COOLING: begin
                        goal = 32'(st.start_width) + 32'(c.minf);
                        if ($urandom_range(0, 1) != 0) w = goal + $urandom_range(0, 300);
                        else if (goal == 0) w = 0;
                        else w = goal - 1 - $urandom_range(0, (goal > 300) ? 300 : goal - 1);
                        if (w > 131071) w = $urandom_range(0, 131071);
                        clock_ms = ($urandom_range(0, 1) != 0)
                                   ? pick_time(st.last_pump, 32'(c.noch))
                                   : pick_time(st.phase_start, 32'(c.cool));
                    end
                    default: begin
                        it.frame_ok = 1'($urandom);
                        clock_ms = pick_time(st.phase_start, 32'(c.cool));
                    end
                endcase
            end
            it.width = w[16:0];
            it.now_ms = clock_ms;
            advance_sequencer(st, seq_regs, it, r);
            sample_q.push_back(it);
        end
    endtask

    // release the queued samples, then hold until every result is back
    task automatic run_phase();
        @(posedge aclk);
        src_go <= 1'b1;
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_valid || due_results.size() != 0);
        @(posedge aclk);
        src_go <= 1'b0;
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 0;
        if (r < 9) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // sender: bursts of transfers separated by idle gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 1;
        end else if (!s_valid || s_ready) begin
            if (src_go && sample_q.size() != 0 && gap_left == 0) begin
                next_item = sample_q.pop_front();
                s_valid <= 1'b1;
                s_camera_id <= next_item.camera_id;
                s_width <= next_item.width;
                s_frame_ok <= next_item.frame_ok;
                s_now_ms <= next_item.now_ms;
                s_pump_open <= next_item.pump_open;
                s_pulse_ok <= next_item.pulse_ok;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= draw_gap();
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
                if (gap_left != 0) gap_left <= gap_left - 1;
            end
        end
    end

    // receiver: changing stall pattern plus occasional long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_tick[5:0] == 6'd63) rx_style <= 2'($urandom);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && rx_tick >= 16'd1500 && s_valid) begin
                hold_done <= 1'b1;
                hold_left <= 300;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 999) == 0) begin
                hold_left <= $urandom_range(80, 250);
                m_ready <= 1'b0;
            end else begin
                case (rx_style)
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= 1'($urandom);
                    2'd2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= rx_tick[2];
                endcase
            end
        end
    end

    // result check first, then the prediction for a sample accepted at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing expected: mode %0d anomaly %0d",
                           m_mode, m_anomaly);
                    fail_cnt++;
                end else begin
                    want = due_results.pop_front();
                    check_field("mode", want.mode, m_mode);
                    check_field("pump_fire", want.pump_fire, m_pump_fire);
                    check_field("fire_camera", want.fire_camera, m_fire_camera);
                    check_field("fire_width", want.fire_width, m_fire_width);
                    check_field("fire_pulse_ms", want.fire_pulse_ms, m_fire_pulse_ms);
                    check_field("anomaly", want.anomaly, m_anomaly);
                end
            end
            if (s_valid && s_ready) begin
                seen.camera_id = s_camera_id;
                seen.width = s_width;
                seen.frame_ok = s_frame_ok;
                seen.now_ms = s_now_ms;
                seen.pump_open = s_pump_open;
                seen.pulse_ok = s_pulse_ok;
                advance_sequencer(seq_st, seq_regs, seen, calc);
                due_results.push_back(calc);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int k;
        seq_regs = '{en: 1'b0, thr: 17'd100, pre: 16'd1000, pls: 15'd50,
                     cool: 20'd0, noch: 16'd1000, minf: 16'd0};
        seq_st = '0;
        seq_st.mode = MODE_STANDBY;
        clock_ms = 32'd0;
        do @(posedge aclk);
        while (!aresetn);

        // disabled after reset
        push_sample(8'd0, 17'd0, 1'b0, 32'd0, 1'b0, 1'b0);
        push_sample(8'd255, 17'd131071, 1'b1, 32'd5, 1'b1, 1'b1);
        run_phase();

        // out-of-range writes saturate; time wraps during this sequence
        program_regs(20'd1, 20'd500, 20'd0, 20'h7FFF, 20'd2000, 20'd0, 20'd100);
        clock_ms = 32'hFFFF_FC00;
        push_sample(8'd255, 17'd131071, 1'b1, 32'd0, 1'b1, 1'b1);
        push_sample(8'd0, 17'd131071, 1'b0, 32'd10, 1'b1, 1'b1);
        push_sample(8'd1, 17'd0, 1'b0, 32'd1999, 1'b1, 1'b1);
        push_sample(8'd1, 17'd0, 1'b1, 32'd1, 1'b1, 1'b1);
        push_sample(8'd7, 17'd499, 1'b1, 32'd5, 1'b1, 1'b1);
        push_sample(8'd8, 17'd499, 1'b1, 32'd999, 1'b0, 1'b1);
        push_sample(8'd9, 17'd100, 1'b1, 32'd1, 1'b0, 1'b1);
        push_sample(8'd9, 17'd100, 1'b1, 32'd2000, 1'b1, 1'b1);
        push_sample(8'd10, 17'd0, 1'b1, 32'd0, 1'b1, 1'b1);
        push_sample(8'd11, 17'd0, 1'b1, 32'd1000, 1'b1, 1'b0);
        push_sample(8'd11, 17'd0, 1'b1, 32'd2000, 1'b1, 1'b1);
        push_sample(8'd12, 17'd300, 1'b1, 32'd0, 1'b1, 1'b1);
        push_sample(8'd13, 17'd300, 1'b1, 32'd1000, 1'b1, 1'b1);
        push_sample(8'd13, 17'd399, 1'b1, 32'd10, 1'b1, 1'b1);
        push_sample(8'd13, 17'd399, 1'b1, 32'd990, 1'b1, 1'b1);
        push_sample(8'd13, 17'd399, 1'b1, 32'd2000, 1'b1, 1'b1);
        push_sample(8'd14, 17'd200, 1'b1, 32'd0, 1'b1, 1'b1);
        push_sample(8'd15, 17'd200, 1'b1, 32'd1000, 1'b1, 1'b1);
        push_sample(8'd15, 17'd300, 1'b1, 32'd500, 1'b1, 1'b1);
        push_sample(8'd15, 17'd300, 1'b1, 32'd600, 1'b1, 1'b1);
        push_sample(8'd15, 17'd300, 1'b1, 32'd900, 1'b1, 1'b1);
        push_sample(8'd16, 17'd499, 1'b1, 32'd0, 1'b1, 1'b1);
        push_sample(8'd16, 17'd500, 1'b1, 32'd10, 1'b1, 1'b1);
        run_phase();

        for (k = 0; k < 8; k++) begin
            case (k)
                0: program_regs(20'd1, 20'h1FFFF, 20'hFFFF, 20'd0, 20'hFFFFF,
                                20'hFFFF, 20'hFFFF);
                1: program_regs(20'd1, 20'd0, 20'd0, 20'h7FFF, 20'd0, 20'd0, 20'd0);
                3: program_regs({19'($urandom), 1'b0}, draw_reg(100, 100000),
                                draw_reg(1000, 60000), draw_reg(50, 20000),
                                draw_reg(0, 600000), draw_reg(1000, 60000),
                                draw_reg(0, 50000));
                default: program_regs({19'($urandom), 1'b1}, draw_reg(100, 100000),
                                      draw_reg(1000, 60000), draw_reg(50, 20000),
                                      draw_reg(0, 600000), draw_reg(1000, 60000),
                                      draw_reg(0, 50000));
            endcase
            clock_ms = (k == 2) ? 32'hFFFF_0000 : $urandom;
            gen_phase((k == 3) ? 60 : 265);
            run_phase();
        end

        repeat (20) @(posedge aclk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/aps_pkg.sv
rtl/core/aps_cfg.sv
rtl/core/aps_fsm.sv
rtl/core/auto_pump_sequencer_unit.sv
dv/tb_top.sv
